/* rtl/dp_longest_common_substring_core_macros.svh */
// assertion helpers used by the datapath
`ifndef DP_LONGEST_COMMON_SUBSTRING_CORE_MACROS_SVH
`define DP_LONGEST_COMMON_SUBSTRING_CORE_MACROS_SVH

// same-cycle implication, masked during reset
`define DPLCS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dplcs assertion failed");

// next-cycle implication, masked during reset
`define DPLCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dplcs assertion failed");

`endif

/* rtl/dplcs_pkg.sv */
package dplcs_pkg;

  // default string capacity
  localparam int unsigned MAX_LEN_DEF = 256;

  // payload widths
  localparam int unsigned SYM_W = 8;
  localparam int unsigned RES_W = 9;

  // op codes
  localparam logic OP_FIRST  = 1'b0;
  localparam logic OP_SECOND = 1'b1;

  // input request payload
  typedef struct packed {
    logic             op;
    logic [SYM_W-1:0] symbol;
    logic             last;
  } in_item_t;

  // result payload
  typedef struct packed {
    logic [RES_W-1:0] start_index;
    logic [RES_W-1:0] match_length;
    logic             overflow;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // input request accepted
    logic run_init;  // clear best, row counter
    logic row_rd;    // fetch first-string char of this row
    logic col_step;  // issue reads for one cell
    logic next_row;  // advance row counter
    logic finish;    // write result, reset job state
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;     // a string has no characters
    logic row_last;  // current row is the last
    logic col_last;  // current column is the last
    logic out_free;  // result register can take a result
  } status_t;

endpackage

/* rtl/dplcs_stream_if.sv */
interface dplcs_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/dplcs_ctrl.sv */
module dplcs_ctrl import dplcs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_is_run_i,
  input  status_t status_i,
  output logic    in_ready_o,
  output cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_ROW   = 3'd2;
  localparam logic [2:0] S_CELL  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_is_run_i) state_d = S_START;
        end
      end
      S_START: begin
        cmd_o.run_init = 1'b1;
        state_d = status_i.empty ? S_DONE : S_ROW;
      end
      S_ROW: begin
        cmd_o.row_rd = 1'b1;
        state_d = S_CELL;
      end
      S_CELL: begin
        cmd_o.col_step = 1'b1;
        if (status_i.col_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (status_i.row_last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.next_row = 1'b1;
          state_d = S_ROW;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/dplcs_dpath.sv */
`include "dp_longest_common_substring_core_macros.svh"

module dplcs_dpath import dplcs_pkg::*; #(
  parameter int unsigned MaxLen = MAX_LEN_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  input  in_item_t  in_data_i,
  input  logic      out_ready_i,
  output status_t   status_o,
  output logic      out_valid_o,
  output out_item_t out_data_o
);

  localparam int unsigned CntW = $clog2(MaxLen + 1);
  localparam int unsigned IdxW = (MaxLen > 1) ? $clog2(MaxLen) : 1;

  logic [SYM_W-1:0] first_mem  [MaxLen];
  logic [SYM_W-1:0] second_mem [MaxLen];
  logic [CntW-1:0]  dp_mem     [MaxLen];

  logic [CntW-1:0]  first_cnt_q, second_cnt_q;
  logic             ovf_q;
  logic [CntW-1:0]  row_q, col_q;
  logic [SYM_W-1:0] first_rd_q, second_rd_q;
  logic [CntW-1:0]  dp_rd_q;
  logic [CntW-1:0]  diag_q;
  logic             first_row_q;
  logic             bvalid_q;
  logic [IdxW-1:0]  bidx_q;
  logic [CntW-1:0]  best_q, end_q;
  logic             out_valid_q;
  out_item_t        out_data_q;

  logic             first_full, second_full;
  logic             wr_first, wr_second;
  logic             match;
  logic [CntW-1:0]  old_col, new_val;

  // append gating
  assign first_full  = (first_cnt_q == CntW'(MaxLen));
  assign second_full = (second_cnt_q == CntW'(MaxLen));
  assign wr_first    = cmd_i.load && (in_data_i.op == OP_FIRST) && !first_full;
  assign wr_second   = cmd_i.load && (in_data_i.op == OP_SECOND) && !second_full;

  // cell update, second stage
  assign match   = (first_rd_q == second_rd_q);
  assign old_col = first_row_q ? '0 : dp_rd_q;
  assign new_val = match ? (diag_q + CntW'(1)) : '0;

  // status to controller
  assign status_o.empty    = (first_cnt_q == '0) || (second_cnt_q == '0);
  assign status_o.row_last = (row_q == (first_cnt_q - CntW'(1)));
  assign status_o.col_last = (col_q == (second_cnt_q - CntW'(1)));
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // string stores
  always_ff @(posedge clk_i) begin
    if (wr_first) first_mem[first_cnt_q[IdxW-1:0]] <= in_data_i.symbol;
    if (wr_second) second_mem[second_cnt_q[IdxW-1:0]] <= in_data_i.symbol;
    if (cmd_i.row_rd) first_rd_q <= first_mem[row_q[IdxW-1:0]];
    if (cmd_i.col_step) second_rd_q <= second_mem[col_q[IdxW-1:0]];
  end

  // dp row store, read ahead of write by one column
  always_ff @(posedge clk_i) begin
    if (bvalid_q) dp_mem[bidx_q] <= new_val;
    if (cmd_i.col_step) dp_rd_q <= dp_mem[col_q[IdxW-1:0]];
  end

  // job counts and overflow flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_cnt_q  <= '0;
      second_cnt_q <= '0;
      ovf_q        <= 1'b0;
    end else if (cmd_i.finish) begin
      first_cnt_q  <= '0;
      second_cnt_q <= '0;
      ovf_q        <= 1'b0;
    end else if (cmd_i.load) begin
      if (wr_first) first_cnt_q <= first_cnt_q + CntW'(1);
      if (wr_second) second_cnt_q <= second_cnt_q + CntW'(1);
      if ((in_data_i.op == OP_FIRST) ? first_full : second_full) ovf_q <= 1'b1;
    end
  end

  // scan counters and pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      col_q       <= '0;
      first_row_q <= 1'b0;
      bvalid_q    <= 1'b0;
    end else begin
      bvalid_q <= cmd_i.col_step;
      if (cmd_i.run_init) begin
        row_q       <= '0;
        first_row_q <= 1'b1;
      end
      if (cmd_i.next_row) begin
        row_q       <= row_q + CntW'(1);
        first_row_q <= 1'b0;
      end
      if (cmd_i.row_rd) col_q <= '0;
      if (cmd_i.col_step) col_q <= col_q + CntW'(1);
    end
  end

  // cell pipeline payload and running best
  always_ff @(posedge clk_i) begin
    if (cmd_i.col_step) bidx_q <= col_q[IdxW-1:0];
    if (cmd_i.row_rd) begin
      diag_q <= '0;
    end else if (bvalid_q) begin
      diag_q <= old_col;
    end
    if (cmd_i.run_init) begin
      best_q <= '0;
      end_q  <= first_cnt_q;
    end else if (bvalid_q && match && (new_val > best_q)) begin
      best_q <= new_val;
      end_q  <= row_q + CntW'(1);
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_data_q.start_index  <= RES_W'(end_q - best_q);
      out_data_q.match_length <= RES_W'(best_q);
      out_data_q.overflow     <= ovf_q;
    end
  end

  // checks
  `DPLCS_ASSERT_NOW(a_cell_in_range, clk_i, rst_ni, cmd_i.col_step, col_q < second_cnt_q)
  `DPLCS_ASSERT_NOW(a_row_in_range, clk_i, rst_ni, cmd_i.row_rd, row_q < first_cnt_q)
  `DPLCS_ASSERT_NOW(a_best_bounded, clk_i, rst_ni, bvalid_q,
                    (best_q <= first_cnt_q) && (best_q <= second_cnt_q))
  `DPLCS_ASSERT_NEXT(a_finish_clears, clk_i, rst_ni, cmd_i.finish,
                     (first_cnt_q == '0) && (second_cnt_q == '0) && !ovf_q && out_valid_q)

endmodule

/* rtl/dp_longest_common_substring_core.sv */
// channel  dir  payload                                 handshake
// in_i     in   op, symbol, last                        valid/ready
// out_o    out  start_index, match_length, overflow     valid/ready
//
// loading: one input request per cycle while no run is active
// run: a start step, then per row a row fetch, the m cells and a drain;
//   the single dp row store is read and written once per cell
// then the result is written; an empty string skips the rows
// input ready is low from the last request until the result is registered
// reset clears the counts, the overflow flag and the result valid
module dp_longest_common_substring_core import dplcs_pkg::*; #(
  parameter int unsigned MaxLen = MAX_LEN_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  dplcs_stream_if.sink          in_i,
  dplcs_stream_if.source        out_o
);

  cmd_t      cmd;
  status_t   status;
  logic      in_is_run;
  in_item_t  in_data;
  out_item_t out_data;

  // run starts on a second-string request marked last
  assign in_data   = in_i.data;
  assign in_is_run = (in_data.op == OP_SECOND) && in_data.last;
  assign out_o.data = out_data;

  dplcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_is_run_i (in_is_run),
    .status_i    (status),
    .in_ready_o  (in_i.ready),
    .cmd_o       (cmd)
  );

  dplcs_dpath #(
    .MaxLen (MaxLen)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data),
    .out_ready_i (out_o.ready),
    .status_o    (status),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_data)
  );

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import dplcs_pkg::*;

  localparam int unsigned CAP = MAX_LEN_DEF;
  localparam int RANDOM_ITEMS = 450;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES = 500;
  localparam int DIR_N = 23;

  // directed row: request plus an optional hand-written expectation
  typedef struct packed {
    in_item_t  req;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  dplcs_stream_if #(.T(in_item_t))  req_if ();
  dplcs_stream_if #(.T(out_item_t)) res_if ();

  dp_longest_common_substring_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  // predictor state
  logic [SYM_W-1:0] first_str [CAP];
  logic [SYM_W-1:0] second_str [CAP];
  logic [RES_W-1:0] first_cnt;
  logic [RES_W-1:0] second_cnt;
  logic             trunc_seen;

  out_item_t        expected_lcs_q [$];
  logic [SYM_W-1:0] job_first [$];
  logic [SYM_W-1:0] job_second [$];

  int  items_sent;
  int  fail_count;
  int  cycles;
  int  hold_left;
  bit  hold_req;
  bit  calm;

  // hand-checked corner cases, then predictor-checked ones
  dir_row_t dir_rows [DIR_N] = '{
    // empty first string
    '{'{OP_SECOND, 8'h00, 1'b1}, 1'b1, '{9'd0, 9'd0, 1'b0}},
    // single all-ones match
    '{'{OP_FIRST,  8'hFF, 1'b0}, 1'b0, '0},
    '{'{OP_SECOND, 8'hFF, 1'b1}, 1'b1, '{9'd0, 9'd1, 1'b0}},
    // no match, last on a first-string request is ignored
    '{'{OP_FIRST,  8'h00, 1'b0}, 1'b0, '0},
    '{'{OP_FIRST,  8'h01, 1'b1}, 1'b0, '0},
    '{'{OP_SECOND, 8'h80, 1'b1}, 1'b1, '{9'd2, 9'd0, 1'b0}},
    // second string spread over two requests
    '{'{OP_FIRST,  8'h41, 1'b1}, 1'b0, '0},
    '{'{OP_FIRST,  8'h42, 1'b1}, 1'b0, '0},
    '{'{OP_SECOND, 8'h41, 1'b0}, 1'b0, '0},
    '{'{OP_SECOND, 8'h42, 1'b1}, 1'b1, '{9'd0, 9'd2, 1'b0}},
    // tie, the earlier first-string position must win
    '{'{OP_FIRST,  8'h58, 1'b0}, 1'b0, '0},
    '{'{OP_FIRST,  8'h41, 1'b0}, 1'b0, '0},
    '{'{OP_FIRST,  8'h59, 1'b0}, 1'b0, '0},
    '{'{OP_FIRST,  8'h41, 1'b0}, 1'b0, '0},
    '{'{OP_SECOND, 8'h41, 1'b1}, 1'b0, '0},
    // longer match after a shorter one
    '{'{OP_FIRST,  8'h55, 1'b0}, 1'b0, '0},
    '{'{OP_FIRST,  8'hAA, 1'b0}, 1'b0, '0},
    '{'{OP_FIRST,  8'h7F, 1'b0}, 1'b0, '0},
    '{'{OP_FIRST,  8'h55, 1'b0}, 1'b0, '0},
    '{'{OP_FIRST,  8'hAA, 1'b0}, 1'b0, '0},
    '{'{OP_SECOND, 8'h7F, 1'b0}, 1'b0, '0},
    '{'{OP_SECOND, 8'h55, 1'b0}, 1'b0, '0},
    '{'{OP_SECOND, 8'hAA, 1'b1}, 1'b0, '0}
  };

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // single-row dp over the loaded strings, one call per accepted request
  function automatic bit lcs_predict(input in_item_t req, output out_item_t res);
    int unsigned row [CAP+1];
    int unsigned best;
    int unsigned end_pos;
    int i;
    int j;
    res = '0;
    if (req.op == OP_FIRST) begin
      if (first_cnt < CAP) begin
        first_str[first_cnt] = req.symbol;
        first_cnt++;
      end else begin
        trunc_seen = 1'b1;
      end
      return 1'b0;
    end
    if (second_cnt < CAP) begin
      second_str[second_cnt] = req.symbol;
      second_cnt++;
    end else begin
      trunc_seen = 1'b1;
    end
    if (!req.last) return 1'b0;

    for (i = 0; i <= CAP; i++) row[i] = 0;
    best = 0;
    end_pos = first_cnt;
    for (i = 1; i <= int'(first_cnt); i++) begin
      // inner scan runs downward so row[j-1] still holds the previous row
      for (j = int'(second_cnt); j >= 1; j--) begin
        if (first_str[i-1] == second_str[j-1]) begin
          row[j] = row[j-1] + 1;
          if (row[j] > best) begin
            best = row[j];
            end_pos = i;
          end
        end else begin
          row[j] = 0;
        end
      end
    end
    res.start_index  = RES_W'(end_pos - best);
    res.match_length = RES_W'(best);
    res.overflow     = trunc_seen;
    first_cnt  = '0;
    second_cnt = '0;
    trunc_seen = 1'b0;
    return 1'b1;
  endfunction

  // offer one request, wait for acceptance, record what it should produce
  task automatic send_req(input in_item_t req, input bit typed, input out_item_t want);
    out_item_t res;
    if (!calm && $urandom_range(0, 99) < 16) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= req;
    do @(posedge clk_i); while (!req_if.ready);
    items_sent++;
    if (lcs_predict(req, res)) begin
      if (typed) res = want;
      expected_lcs_q = {expected_lcs_q, res};
    end
    @(negedge clk_i);
  endtask

  // send the queued strings, interleaved at random, last on the final second char
  task automatic send_job();
    int fi;
    int si;
    bit take_first;
    in_item_t req;
    fi = 0;
    si = 0;
    while (fi < job_first.size() || si < job_second.size()) begin
      take_first = (fi < job_first.size()) &&
                   ((si + 1 >= job_second.size()) || ($urandom_range(0, 1) == 1));
      if (take_first) begin
        req.op     = OP_FIRST;
        req.symbol = job_first[fi];
        req.last   = 1'($urandom_range(0, 1));
        fi++;
      end else begin
        req.op     = OP_SECOND;
        req.symbol = job_second[si];
        si++;
        req.last   = (si == job_second.size());
      end
      send_req(req, 1'b0, '0);
    end
  endtask

  // narrow alphabets make matches likely, mode 0 is plain noise
  function automatic logic [SYM_W-1:0] pick_sym(input int mode, input logic [SYM_W-1:0] base);
    case (mode)
      0: return SYM_W'($urandom_range(0, 255));
      1: return base + SYM_W'($urandom_range(0, 1));
      default: return base + SYM_W'($urandom_range(0, 3));
    endcase
  endfunction

  // random job; mode 3 copies a slice of the first string with some damage
  task automatic make_job(input int nf, input int ns);
    int mode;
    int off;
    logic [SYM_W-1:0] base;
    mode = $urandom_range(0, 3);
    base = SYM_W'($urandom_range(0, 255));
    off  = $urandom_range(0, 63);
    job_first.delete();
    job_second.delete();
    for (int k = 0; k < nf; k++) job_first = {job_first, pick_sym(mode, base)};
    for (int k = 0; k < ns; k++) begin
      if (mode == 3 && nf > 0 && $urandom_range(0, 5) != 0)
        job_second = {job_second, job_first[(off + k) % nf]};
      else
        job_second = {job_second, pick_sym(mode, base)};
    end
  endtask

  // result sink with random stalls and one long hold-off
  initial begin
    res_if.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= calm || ($urandom_range(0, 99) >= 16);
      end
    end
  end

  // compare each accepted result against the oldest expectation
  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_lcs_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: start %0d len %0d ovf %0d",
                   res_if.data.start_index, res_if.data.match_length,
                   res_if.data.overflow);
      end else begin
        want = expected_lcs_q.pop_front();
        if (res_if.data.start_index !== want.start_index ||
            res_if.data.match_length !== want.match_length ||
            res_if.data.overflow !== want.overflow) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: exp start %0d len %0d ovf %0d, got start %0d len %0d ovf %0d",
                     want.start_index, want.match_length, want.overflow,
                     res_if.data.start_index, res_if.data.match_length,
                     res_if.data.overflow);
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // stimulus
  initial begin
    int rand_items;
    int job_idx;
    int nf;
    int ns;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    first_cnt = '0;
    second_cnt = '0;
    trunc_seen = 1'b0;
    items_sent = 0;
    fail_count = 0;
    cycles = 0;
    hold_req = 1'b0;
    calm = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part
    for (int k = 0; k < DIR_N; k++)
      send_req(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].want);

    // sender pauses until everything has drained
    req_if.valid <= 1'b0;
    wait (expected_lcs_q.size() == 0);
    @(negedge clk_i);

    // capacity: first string overflows, short second string
    make_job(CAP + 4, 3);
    send_job();
    // full first string with no match gives start at the end
    job_first.delete();
    job_second.delete();
    for (int k = 0; k < CAP; k++) job_first = {job_first, 8'h00};
    job_second = {job_second, 8'h01};
    send_job();
    // full-length match, second string overflows
    job_first.delete();
    job_second.delete();
    for (int k = 0; k < CAP; k++) job_first = {job_first, 8'h5A};
    for (int k = 0; k <= CAP; k++) job_second = {job_second, 8'h5A};
    send_job();

    // random jobs, mostly small
    rand_items = items_sent;
    job_idx = 0;
    while (items_sent - rand_items < RANDOM_ITEMS) begin
      calm = (job_idx >= 12 && job_idx < 22);
      if (job_idx == 6) hold_req = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        nf = $urandom_range(0, 40);
        ns = $urandom_range(1, 40);
      end else begin
        nf = $urandom_range(0, 12);
        ns = $urandom_range(1, 12);
      end
      make_job(nf, ns);
      send_job();
      job_idx++;
    end
    calm = 1'b0;

    // wind down
    req_if.valid <= 1'b0;
    wait (expected_lcs_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
